// ===== sv/svp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svp_pkg;

   // Field widths
   localparam int PulseW  = 12;
   localparam int SpanW   = 10;
   localparam int BandW   = 10;
   localparam int StepW   = 8;
   localparam int AgeW    = 8;
   localparam int IntentW = 16;
   localparam int ProdW   = IntentW + SpanW;
   localparam int QuotW   = 16;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 12;

   // Reciprocal of 1000: floor(p / 1000) == (p * RecipMult) >> RecipShift for p < 2**25
   localparam int RecipShift = 35;
   localparam logic [ProdW-1:0] RecipMult = 26'd34359739;

   // Reset values
   localparam logic [PulseW-1:0] NeutralReset = 12'd1500;
   localparam logic [PulseW-1:0] MinReset     = 12'd900;
   localparam logic [PulseW-1:0] MaxReset     = 12'd2100;
   localparam logic [SpanW-1:0]  SpanReset    = 10'd450;
   localparam logic [BandW-1:0]  BandReset    = 10'd20;
   localparam logic [StepW-1:0]  StepReset    = 8'd12;
   localparam logic [AgeW-1:0]   TimeoutReset = 8'd15;
   localparam logic [AgeW-1:0]   AgeMax       = 8'd255;

   // Register indexes
   typedef enum logic [CsrIdxW-1:0] {
      REG_NEUTRAL = 3'd0,
      REG_MIN     = 3'd1,
      REG_MAX     = 3'd2,
      REG_SPAN    = 3'd3,
      REG_BAND    = 3'd4,
      REG_STEP    = 3'd5,
      REG_TIMEOUT = 3'd6,
      REG_INVERT  = 3'd7
   } svp_reg_type;

   typedef struct packed {
      logic [PulseW-1:0] neutral;
      logic [PulseW-1:0] min_pulse;
      logic [PulseW-1:0] max_pulse;
      logic [SpanW-1:0]  span;
      logic [BandW-1:0]  band;
      logic [StepW-1:0]  step;
      logic [AgeW-1:0]   timeout;
      logic              invert;
   } svp_cfg_type;

   // Beat after the span multiply
   typedef struct packed {
      logic             is_tick;
      logic             cal;
      logic             in_band;
      logic             neg;
      logic [ProdW-1:0] prod;
   } svp_prod_type;

   // Beat after the divide by 1000
   typedef struct packed {
      logic             is_tick;
      logic             cal;
      logic             in_band;
      logic             neg;
      logic [QuotW-1:0] quot;
   } svp_scaled_type;

endpackage

`default_nettype wire

// ===== sv/servo_pulse_slew_with_link_watchdog.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Beat contents
// req_*   | in  | packet (tuser 0) or control tick (tuser 1); intent and calibrated flag
// rsp_*   | out | one beat per tick: commanded pulse width and link status
// csr_*   | in  | register write, index 0..7, no read-back
//
// Ticks pass input, product, stage-3 and result registers; one beat is taken per cycle unless stalled.
// The span multiply, the reciprocal divide by 1000 and the clamp/slew logic
// each own one register stage.
// Packet beats retire inside the block and give no result.
// Synchronous reset restores the register defaults and neutral pulse; no clearing pass.
// A stalled result stops the pipe once a tick reaches the last stage; packets ahead of
// that tick keep retiring, and then three beats wait behind the held result.

module servo_pulse_slew_with_link_watchdog (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire [2:0]   csr_index,
   input  wire [11:0]  csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [23:0]  req_tdata,   // [15:0] intent_value, [16] calibrated_flag, rest zero
   input  wire [0:0]   req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // [11:0] pulse_us, [12] link_up, rest zero
);
   import svp_pkg::*;

   svp_cfg_type       cfg;
   logic              sc_valid;
   logic              sc_ready;
   svp_scaled_type    sc_beat;
   logic [PulseW-1:0] pulse;
   logic              link_up;

   svp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   svp_intent_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_tick   (req_tuser[0]),
      .in_intent (req_tdata[15:0]),
      .in_cal    (req_tdata[16]),
      .out_valid (sc_valid),
      .out_ready (sc_ready),
      .out_beat  (sc_beat)
   );

   svp_pulse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (sc_valid),
      .in_ready    (sc_ready),
      .in_beat     (sc_beat),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_pulse   (pulse),
      .rsp_link_up (link_up)
   );

   assign rsp_tdata = {3'b0, link_up, pulse};

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // With the result register free the whole pipeline moves, so input is taken
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // Hold a stalled result beat unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while stalled");

endmodule

`default_nettype wire

// ===== sv/svp_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svp_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wr_en,
   input  wire [svp_pkg::CsrIdxW-1:0]       csr_index,
   input  wire [svp_pkg::CsrDatW-1:0]       csr_wdata,
   output svp_pkg::svp_cfg_type             cfg
);
   import svp_pkg::*;

   svp_cfg_type cfg_ff;
   svp_cfg_type cfg_in;
   svp_reg_type idx;

   assign idx = svp_reg_type'(csr_index);

   // Decode the write into the register set
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (idx)
            REG_NEUTRAL: cfg_in.neutral   = csr_wdata[PulseW-1:0];
            REG_MIN:     cfg_in.min_pulse = csr_wdata[PulseW-1:0];
            REG_MAX:     cfg_in.max_pulse = csr_wdata[PulseW-1:0];
            REG_SPAN:    cfg_in.span      = csr_wdata[SpanW-1:0];
            REG_BAND:    cfg_in.band      = csr_wdata[BandW-1:0];
            REG_STEP:    cfg_in.step      = csr_wdata[StepW-1:0];
            REG_TIMEOUT: cfg_in.timeout   = csr_wdata[AgeW-1:0];
            REG_INVERT:  cfg_in.invert    = csr_wdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral   <= NeutralReset;
         cfg_ff.min_pulse <= MinReset;
         cfg_ff.max_pulse <= MaxReset;
         cfg_ff.span      <= SpanReset;
         cfg_ff.band      <= BandReset;
         cfg_ff.step      <= StepReset;
         cfg_ff.timeout   <= TimeoutReset;
         cfg_ff.invert    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/svp_intent_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svp_intent_scale (
   input  wire                              clock,
   input  wire                              reset,
   input  wire svp_pkg::svp_cfg_type        cfg,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire                              in_tick,
   input  wire [svp_pkg::IntentW-1:0]       in_intent,
   input  wire                              in_cal,
   output logic                             out_valid,
   input  wire                              out_ready,
   output svp_pkg::svp_scaled_type          out_beat
);
   import svp_pkg::*;

   // Input register
   logic               v1_ff;
   logic               tick1_ff;
   logic [IntentW-1:0] intent1_ff;
   logic               cal1_ff;

   // Packet contents as seen by the beat in the input register
   logic [IntentW-1:0] held_intent_ff;
   logic               held_cal_ff;

   // Product register
   logic               v2_ff;
   svp_prod_type       st2_ff;
   svp_prod_type       st2_in;

   logic               move2;
   logic [IntentW-1:0] eff_intent;
   logic [IntentW-1:0] mag;
   logic [2*ProdW-1:0] recip_full;

   // Advance when the next stage has room
   assign move2    = !v2_ff || out_ready;
   assign in_ready = !v1_ff || move2;

   // A packet uses its own intent, a tick the latest stored one
   assign eff_intent = tick1_ff ? held_intent_ff : intent1_ff;
   assign mag        = eff_intent[IntentW-1] ? (~eff_intent + 1'b1) : eff_intent;

   always_comb begin
      st2_in.is_tick = tick1_ff;
      st2_in.cal     = tick1_ff ? held_cal_ff : cal1_ff;
      st2_in.in_band = mag >= IntentW'(cfg.band);
      st2_in.neg     = eff_intent[IntentW-1];
      st2_in.prod    = ProdW'(mag) * ProdW'(cfg.span);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         held_intent_ff <= '0;
         held_cal_ff    <= 1'b0;
      end else begin
         if (in_ready) begin
            v1_ff <= in_valid;
         end
         if (move2) begin
            v2_ff <= v1_ff;
         end
         // Store packet contents as the packet leaves the input register
         if (v1_ff && move2 && !tick1_ff) begin
            held_intent_ff <= intent1_ff;
            held_cal_ff    <= cal1_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tick1_ff   <= in_tick;
         intent1_ff <= in_intent;
         cal1_ff    <= in_cal;
      end
      if (move2) begin
         st2_ff <= st2_in;
      end
   end

   // Divide the product by 1000 through the reciprocal
   assign recip_full = {{ProdW{1'b0}}, st2_ff.prod} * {{ProdW{1'b0}}, RecipMult};

   always_comb begin
      out_beat.is_tick = st2_ff.is_tick;
      out_beat.cal     = st2_ff.cal;
      out_beat.in_band = st2_ff.in_band;
      out_beat.neg     = st2_ff.neg;
      out_beat.quot    = recip_full[RecipShift +: QuotW];
   end

   assign out_valid = v2_ff;

endmodule

`default_nettype wire

// ===== sv/svp_pulse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svp_pulse_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire svp_pkg::svp_cfg_type        cfg,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire svp_pkg::svp_scaled_type     in_beat,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [svp_pkg::PulseW-1:0]       rsp_pulse,
   output logic                             rsp_link_up
);
   import svp_pkg::*;

   logic              v3_ff;
   svp_scaled_type    st3_ff;

   logic [PulseW-1:0] cur_ff;
   logic [PulseW-1:0] cur_in;
   logic              seen_ff;
   logic [AgeW-1:0]   age_ff;

   logic              rsp_valid_ff;
   logic [PulseW-1:0] rsp_pulse_ff;
   logic              rsp_up_ff;

   logic              out_free;
   logic              fire;
   logic              link_up;
   logic              neg;
   logic signed [16:0] neutral_s;
   logic signed [16:0] off_s;
   logic signed [16:0] sum_s;
   logic [PulseW-1:0] clamped;
   logic [PulseW-1:0] target;
   logic [PulseW:0]   up_sum;
   logic [PulseW-1:0] diff;

   // Packets retire freely, ticks need room in the result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = v3_ff && (!st3_ff.is_tick || out_free);
   assign in_ready = !v3_ff || fire;

   assign link_up = seen_ff && (age_ff < cfg.timeout);

   // Offset, sign, clamp and neutral fallback
   always_comb begin
      neg       = st3_ff.neg ^ cfg.invert;
      neutral_s = $signed({5'b0, cfg.neutral});
      off_s     = $signed({1'b0, st3_ff.quot});
      sum_s     = neg ? (neutral_s - off_s) : (neutral_s + off_s);
      if (sum_s < $signed({5'b0, cfg.min_pulse})) begin
         clamped = cfg.min_pulse;
      end else if (sum_s > $signed({5'b0, cfg.max_pulse})) begin
         clamped = cfg.max_pulse;
      end else begin
         clamped = sum_s[PulseW-1:0];
      end
      if (!link_up || !st3_ff.cal || !st3_ff.in_band) begin
         target = cfg.neutral;
      end else begin
         target = clamped;
      end
   end

   // Slew toward the target
   always_comb begin
      up_sum = {1'b0, cur_ff} + {5'b0, cfg.step};
      diff   = cur_ff - target;
      cur_in = cur_ff;
      if (cur_ff < target) begin
         cur_in = (up_sum < {1'b0, target}) ? up_sum[PulseW-1:0] : target;
      end else if (cur_ff > target) begin
         cur_in = (diff > {4'b0, cfg.step}) ? (cur_ff - {4'b0, cfg.step}) : target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         cur_ff       <= NeutralReset;
         seen_ff      <= 1'b0;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            v3_ff <= in_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= fire && st3_ff.is_tick;
         end
         if (fire) begin
            if (st3_ff.is_tick) begin
               cur_ff <= cur_in;
               if (age_ff != AgeMax) begin
                  age_ff <= age_ff + 1'b1;
               end
            end else begin
               seen_ff <= 1'b1;
               age_ff  <= '0;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         st3_ff <= in_beat;
      end
      if (fire && st3_ff.is_tick) begin
         rsp_pulse_ff <= cur_in;
         rsp_up_ff    <= link_up;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pulse   = rsp_pulse_ff;
   assign rsp_link_up = rsp_up_ff;

endmodule

`default_nettype wire
